// ===== hdl/i2cbe_pkg.sv =====
// Package for the I2C master bit engine: command codes, engine state and result records.
// Used by i2cbe_step and i2c_master_bit_engine_core; depends on nothing else.

package i2cbe_pkg;

   localparam int unsigned HALF_PERIOD_W     = 8;
   localparam int unsigned HALF_PERIOD_RESET = 5;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned BIT_IDX_W         = $clog2(BYTE_W);
   localparam int unsigned REQ_TDATA_W       = 16;
   localparam int unsigned REQ_TUSER_W       = 3;
   localparam int unsigned RSP_TDATA_W       = 16;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_WRITE    = 3'd3,
      CMD_READ     = 3'd4,
      CMD_ACK      = 3'd5,
      CMD_NACK     = 3'd6,
      CMD_READ_ACK = 3'd7
   } cmd_type;

   // Everything the engine keeps from one tick to the next.
   typedef struct packed {
      cmd_type                     cmd;
      logic                        phase;      // 0: before the middle action, 1: after it
      logic [BIT_IDX_W-1:0]        bit_count;
      logic [HALF_PERIOD_W-1:0]    tick_count;
      logic [BYTE_W-1:0]           shift;
      logic                        scl;
      logic                        sda;
      logic                        sda_in_mode;
      logic                        ack;
      logic [BYTE_W-1:0]           last_read;
   } eng_state_type;

   // One result item, as it leaves the block.
   typedef struct packed {
      logic                        rejected;
      logic                        ack_seen;
      logic [BYTE_W-1:0]           read_byte;
      logic                        done_res;
      logic                        busy_res;
      logic                        sda_input_mode;
      logic                        sda_drive;
      logic                        scl_level;
   } rsp_type;

endpackage

// ===== hdl/i2cbe_step.sv =====
// One tick of the I2C bit engine: next engine state and the result item for that tick.
// Purely combinational; depends on i2cbe_pkg.

module i2cbe_step
   import i2cbe_pkg::*;
(
   input  eng_state_type            cur,
   input  logic [HALF_PERIOD_W-1:0] half_period,
   input  cmd_type                  func,
   input  logic [BYTE_W-1:0]        write_byte,
   input  logic                     sda_level,
   output eng_state_type            nxt,
   output rsp_type                  rsp
);

   logic [HALF_PERIOD_W-1:0] eff_half;
   logic [HALF_PERIOD_W-1:0] tick_inc;
   logic                     delay_end;
   logic                     rejected;
   logic                     done;
   logic                     last_bit;
   logic [BYTE_W-1:0]        shift_wr;
   logic [BYTE_W-1:0]        shift_rd;

   // A zero delay behaves as a delay of one tick.
   assign eff_half  = (half_period == '0) ? HALF_PERIOD_W'(1) : half_period;
   assign tick_inc  = cur.tick_count + HALF_PERIOD_W'(1);
   assign delay_end = (tick_inc >= eff_half) || (tick_inc == '0);
   assign last_bit  = (cur.bit_count == '1);
   assign shift_wr  = {cur.shift[BYTE_W-2:0], 1'b0};
   assign shift_rd  = {cur.shift[BYTE_W-2:0], sda_level};

   always_comb begin
      nxt      = cur;
      rejected = 1'b0;
      done     = 1'b0;
      if (cur.cmd == CMD_NONE) begin
         if (func != CMD_NONE) begin
            nxt.cmd        = func;
            nxt.phase      = 1'b0;
            nxt.bit_count  = '0;
            nxt.tick_count = '0;
            unique case (func)
               CMD_START: begin
                  nxt.sda_in_mode = 1'b0;
                  nxt.scl         = 1'b1;
                  nxt.sda         = 1'b1;
               end
               CMD_STOP, CMD_ACK: begin
                  nxt.sda_in_mode = 1'b0;
                  nxt.sda         = 1'b0;
               end
               CMD_WRITE: begin
                  nxt.sda_in_mode = 1'b0;
                  nxt.shift       = write_byte;
                  nxt.sda         = write_byte[BYTE_W-1];
               end
               CMD_READ: begin
                  nxt.sda_in_mode = 1'b1;
                  nxt.shift       = '0;
               end
               CMD_NACK: begin
                  nxt.sda_in_mode = 1'b0;
                  nxt.sda         = 1'b1;
               end
               CMD_READ_ACK, CMD_NONE: begin
                  nxt.sda_in_mode = 1'b1;
               end
            endcase
         end
      end else begin
         rejected       = (func != CMD_NONE);
         nxt.tick_count = tick_inc;
         if (delay_end) begin
            nxt.tick_count = '0;
            if (!cur.phase) begin
               // Middle action: SDA falls for a start, otherwise SCL rises.
               if (cur.cmd == CMD_START) begin
                  nxt.sda = 1'b0;
               end else begin
                  nxt.scl = 1'b1;
               end
               nxt.phase = 1'b1;
            end else begin
               done = 1'b1;
               unique case (cur.cmd)
                  CMD_STOP: begin
                     nxt.sda = 1'b1;
                  end
                  CMD_WRITE: begin
                     nxt.scl = 1'b0;
                     if (!last_bit) begin
                        done          = 1'b0;
                        nxt.bit_count = cur.bit_count + BIT_IDX_W'(1);
                        nxt.shift     = shift_wr;
                        nxt.sda       = shift_wr[BYTE_W-1];
                        nxt.phase     = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     nxt.scl   = 1'b0;
                     nxt.shift = shift_rd;
                     if (!last_bit) begin
                        done          = 1'b0;
                        nxt.bit_count = cur.bit_count + BIT_IDX_W'(1);
                        nxt.phase     = 1'b0;
                     end else begin
                        nxt.last_read = shift_rd;
                     end
                  end
                  CMD_READ_ACK: begin
                     nxt.scl = 1'b0;
                     nxt.ack = ~sda_level;
                  end
                  CMD_START, CMD_ACK, CMD_NACK, CMD_NONE: begin
                     nxt.scl = 1'b0;
                  end
               endcase
               if (done) begin
                  nxt.cmd        = CMD_NONE;
                  nxt.phase      = 1'b0;
                  nxt.bit_count  = '0;
                  nxt.tick_count = '0;
               end
            end
         end
      end
   end

   always_comb begin
      rsp.scl_level      = nxt.scl;
      rsp.sda_drive      = nxt.sda;
      rsp.sda_input_mode = nxt.sda_in_mode;
      rsp.busy_res       = (nxt.cmd != CMD_NONE);
      rsp.done_res       = done;
      rsp.read_byte      = nxt.last_read;
      rsp.ack_seen       = nxt.ack;
      rsp.rejected       = rejected;
   end

endmodule

// ===== hdl/i2c_master_bit_engine_core.sv =====
// Top level of the I2C master bit engine: handshakes, state and result registers.
// Depends on i2cbe_pkg and i2cbe_step.
//
// Usage. Each item on the req_ channel is one base tick of the bus timing. It
// carries an optional command in req_tuser (none, start, stop, write byte, read
// byte, send ACK, send NACK, read ACK), the byte to send and the SDA level seen
// on that tick. Every accepted item gives exactly one item on the rsp_ channel
// with the pin levels to drive after that tick, the busy and done flags, the
// last byte read, the last ACK seen and a flag for a command that was refused
// because a sequence was still running.
// The csr_ channel writes the half period in ticks; it is always ready and is
// meant to be written while no sequence is running.
// The result is registered and valid in the cycle after acceptance. The engine
// takes one item every clock cycle while the receiver keeps up: the tick update is
// a single pass of short logic from the state register into the result register.
// When the receiver stalls, the result register holds its item and req_tready
// falls, so no tick is lost or doubled; the result register frees as soon as
// its item is taken, in the same cycle as a new item enters.
// Reset leaves the bus idle with SCL and SDA high, SDA driven, no sequence
// active, the half period at five ticks and no result pending.

module i2c_master_bit_engine_core
   import i2cbe_pkg::*;
#(
   parameter int unsigned HalfPeriodReset = HALF_PERIOD_RESET
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input ticks.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // [7:0] write_byte, [8] sda_level, rest zero
   input  logic [REQ_TUSER_W-1:0]   req_tuser,   // [2:0] func
   // Results.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,   // [0] scl_level, [1] sda_drive,
                                                 // [2] sda_input_mode, [3] busy_res,
                                                 // [4] done_res, [12:5] read_byte,
                                                 // [13] ack_seen, [14] rejected, [15] zero
   // Half period register.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [HALF_PERIOD_W-1:0] csr_data
);

   logic [HALF_PERIOD_W-1:0] half_ff;
   logic [HALF_PERIOD_W-1:0] half_in;
   eng_state_type            st_ff;
   eng_state_type            st_in;
   eng_state_type            st_step;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   rsp_type                  rsp_step;
   logic                     rsp_tvalid_ff;
   logic                     rsp_tvalid_in;
   logic                     req_accept;

   assign csr_ready  = 1'b1;
   assign half_in    = (csr_valid && csr_ready) ? csr_data : half_ff;

   // The result register is free when empty or when its item leaves this cycle.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   i2cbe_step u_step (
      .cur         (st_ff),
      .half_period (half_ff),
      .func        (cmd_type'(req_tuser[2:0])),
      .write_byte  (req_tdata[BYTE_W-1:0]),
      .sda_level   (req_tdata[BYTE_W]),
      .nxt         (st_step),
      .rsp         (rsp_step)
   );

   assign st_in         = req_accept ? st_step : st_ff;
   assign rsp_in        = req_accept ? rsp_step : rsp_ff;
   assign rsp_tvalid_in = req_accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff             <= HALF_PERIOD_W'(HalfPeriodReset);
         st_ff.cmd           <= CMD_NONE;
         st_ff.phase         <= 1'b0;
         st_ff.bit_count     <= '0;
         st_ff.tick_count    <= '0;
         st_ff.shift         <= '0;
         st_ff.scl           <= 1'b1;
         st_ff.sda           <= 1'b1;
         st_ff.sda_in_mode   <= 1'b0;
         st_ff.ack           <= 1'b0;
         st_ff.last_read     <= '0;
         rsp_tvalid_ff       <= 1'b0;
      end else begin
         half_ff             <= half_in;
         st_ff               <= st_in;
         rsp_tvalid_ff       <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // A finished sequence never reports itself busy on the same tick.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done and busy reported together");

   // An idle engine keeps its counters and phase cleared.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff.cmd == CMD_NONE |-> st_ff.tick_count == '0 && st_ff.bit_count == '0 && !st_ff.phase)
      else $error("idle engine holds a stale count");

   // A command on an idle tick is never rejected.
   a_no_reject_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && st_ff.cmd == CMD_NONE |=> !rsp_ff.rejected)
      else $error("command rejected while idle");

   // Only byte commands step through bits.
   a_bits_byte_only: assert property (@(posedge clock) disable iff (reset)
      st_ff.bit_count != '0 |-> st_ff.cmd == CMD_WRITE || st_ff.cmd == CMD_READ)
      else $error("bit count moved outside a byte command");

endmodule

// ===== verif/tb_i2c_master_bit_engine_core.sv =====
// Self-checking testbench for i2c_master_bit_engine_core: bus ticks in, pin levels out.
// Depends on i2cbe_pkg and the core RTL only; stimulus and prediction live in this file.

module tb_i2c_master_bit_engine_core
   import i2cbe_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_BITS   = $bits(rsp_type);
   localparam int STALL_LIMIT = 2000;

   // The tracker mirrors the engine one tick at a time. Each accepted tick
   // pushes the pin levels and flags the engine must show after that tick;
   // each accepted result item is compared against the oldest of them.
   class bus_pin_tracker;
      logic [HALF_PERIOD_W-1:0] half_period;
      cmd_type                  cmd;
      logic                     phase;
      logic [3:0]               bit_cnt;
      logic [7:0]               tick_cnt;
      logic [BYTE_W-1:0]        shift;
      logic                     scl;
      logic                     sda;
      logic                     sda_in_mode;
      logic                     ack;
      logic [BYTE_W-1:0]        last_read;
      rsp_type                  pin_levels_q[$];
      int                       mismatches;

      function new();
         half_period = HALF_PERIOD_W'(HALF_PERIOD_RESET);
         cmd         = CMD_NONE;
         phase       = 1'b0;
         bit_cnt     = '0;
         tick_cnt    = '0;
         shift       = '0;
         scl         = 1'b1;
         sda         = 1'b1;
         sda_in_mode = 1'b0;
         ack         = 1'b0;
         last_read   = '0;
         mismatches  = 0;
      endfunction

      function void set_half_period(logic [HALF_PERIOD_W-1:0] value);
         half_period = value;
      endfunction

      function bit engine_busy();
         return cmd != CMD_NONE;
      endfunction

      function int pending();
         return pin_levels_q.size();
      endfunction

      function void note_tick(cmd_type func, logic [7:0] data, logic sda_in);
         logic [7:0] delay;
         logic       refused;
         logic       finished;
         rsp_type    levels;
         delay    = (half_period == 0) ? 8'd1 : half_period;
         refused  = 1'b0;
         finished = 1'b0;
         if (cmd == CMD_NONE) begin
            if (func != CMD_NONE) begin
               // Opening pin action lands on the accepting tick.
               cmd      = func;
               phase    = 1'b0;
               bit_cnt  = '0;
               tick_cnt = '0;
               case (func)
                  CMD_START: begin
                     sda_in_mode = 1'b0; scl = 1'b1; sda = 1'b1;
                  end
                  CMD_STOP, CMD_ACK: begin
                     sda_in_mode = 1'b0; sda = 1'b0;
                  end
                  CMD_WRITE: begin
                     sda_in_mode = 1'b0; shift = data; sda = data[7];
                  end
                  CMD_READ: begin
                     sda_in_mode = 1'b1; shift = '0;
                  end
                  CMD_NACK: begin
                     sda_in_mode = 1'b0; sda = 1'b1;
                  end
                  default: begin
                     sda_in_mode = 1'b1;
                  end
               endcase
            end
         end else begin
            if (func != CMD_NONE) refused = 1'b1;
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= delay || tick_cnt == 0) begin
               tick_cnt = '0;
               if (!phase) begin
                  if (cmd == CMD_START) sda = 1'b0;
                  else scl = 1'b1;
                  phase = 1'b1;
               end else begin
                  // Closing action; byte commands loop back for the next bit.
                  finished = 1'b1;
                  if (cmd != CMD_STOP) scl = 1'b0;
                  case (cmd)
                     CMD_STOP: sda = 1'b1;
                     CMD_WRITE: begin
                        if (bit_cnt < 7) begin
                           bit_cnt  = bit_cnt + 4'd1;
                           shift    = shift << 1;
                           sda      = shift[7];
                           phase    = 1'b0;
                           finished = 1'b0;
                        end
                     end
                     CMD_READ: begin
                        shift = {shift[6:0], sda_in};
                        if (bit_cnt < 7) begin
                           bit_cnt  = bit_cnt + 4'd1;
                           phase    = 1'b0;
                           finished = 1'b0;
                        end else begin
                           last_read = shift;
                        end
                     end
                     CMD_READ_ACK: ack = ~sda_in;
                     default: ;
                  endcase
                  if (finished) begin
                     cmd      = CMD_NONE;
                     phase    = 1'b0;
                     bit_cnt  = '0;
                     tick_cnt = '0;
                  end
               end
            end
         end
         levels.scl_level      = scl;
         levels.sda_drive      = sda;
         levels.sda_input_mode = sda_in_mode;
         levels.busy_res       = (cmd != CMD_NONE);
         levels.done_res       = finished;
         levels.read_byte      = last_read;
         levels.ack_seen       = ack;
         levels.rejected       = refused;
         pin_levels_q.push_back(levels);
      endfunction

      task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
         mismatches++;
         $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
      endtask

      task check_pins(logic [RSP_TDATA_W-1:0] word);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(word[RSP_BITS-1:0]);
         if (pin_levels_q.size() == 0) begin
            report_mismatch("result with nothing pending", 16'(word), '0);
            return;
         end
         want = pin_levels_q.pop_front();
         if ((word >> RSP_BITS) != 0)
            report_mismatch("padding", 16'(word >> RSP_BITS), '0);
         if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", 16'(got.scl_level), 16'(want.scl_level));
         if (got.sda_drive !== want.sda_drive)
            report_mismatch("sda_drive", 16'(got.sda_drive), 16'(want.sda_drive));
         if (got.sda_input_mode !== want.sda_input_mode)
            report_mismatch("sda_input_mode", 16'(got.sda_input_mode),
                            16'(want.sda_input_mode));
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
         if (got.done_res !== want.done_res)
            report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
         if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
         if (got.ack_seen !== want.ack_seen)
            report_mismatch("ack_seen", 16'(got.ack_seen), 16'(want.ack_seen));
         if (got.rejected !== want.rejected)
            report_mismatch("rejected", 16'(got.rejected), 16'(want.rejected));
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;   // [7:0] write_byte, [8] sda_level, rest zero
   logic [REQ_TUSER_W-1:0]   req_tuser;   // [2:0] func
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;   // [0] scl_level, [1] sda_drive, [2] sda_input_mode,
                                          // [3] busy_res, [4] done_res, [12:5] read_byte,
                                          // [13] ack_seen, [14] rejected, [15] zero
   logic                     csr_valid;
   logic                     csr_ready;
   logic [HALF_PERIOD_W-1:0] csr_data;

   // Percent of cycles in which the sender and the receiver hold back.
   int tx_idle_pct;
   int rx_idle_pct;

   bus_pin_tracker pins = new();

   i2c_master_bit_engine_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sender side. Every task returns just after a rising edge without having
   // touched req_tvalid in that step, so the next task may drive it once.

   // Hold off the next item for a random number of cycles.
   task sender_pause();
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   // Offer one tick and note it in the tracker once the core takes it.
   task drive_tick(cmd_type func, logic [7:0] data, logic sda_in);
      sender_pause();
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_TDATA_W'({sda_in, data});
      do @(posedge clock); while (!req_tready);
      pins.note_tick(func, data, sda_in);
   endtask

   // Stop sending until every pending result item has been taken.
   task wait_drained();
      req_tvalid <= 1'b0;
      while (pins.pending() > 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task write_half_period(logic [HALF_PERIOD_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      pins.set_half_period(value);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic: a command is issued while the engine is idle,
   // plain ticks run it out, and now and then a command lands mid-sequence.
   task random_tick();
      cmd_type func;
      func = CMD_NONE;
      if (!pins.engine_busy()) begin
         if ($urandom_range(99) < 60) func = cmd_type'(3'($urandom_range(7, 1)));
      end else if ($urandom_range(99) < 8) begin
         func = cmd_type'(3'($urandom_range(7, 1)));
      end
      drive_tick(func, 8'($urandom), 1'($urandom));
   endtask

   task run_random_ticks(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(49) == 0) wait_drained();
         random_tick();
      end
   endtask

   task run_until_idle();
      while (pins.engine_busy()) random_tick();
   endtask

   initial begin : stimulus
      int hp_list[3];
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_NONE;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      tx_idle_pct = 30;
      rx_idle_pct = 72;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A zero half period must behave like one tick, so every
      // short command here runs in three ticks.
      write_half_period(8'd0);
      drive_tick(CMD_NONE, 8'hFF, 1'b0);
      // Start; the commands on its middle and finishing ticks must be refused.
      drive_tick(CMD_START, 8'h00, 1'b1);
      drive_tick(CMD_WRITE, 8'h5A, 1'b0);
      drive_tick(CMD_STOP, 8'hA5, 1'b1);
      drive_tick(CMD_ACK, 8'h00, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b1);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      drive_tick(CMD_NACK, 8'hFF, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b1);
      // Read ACK once with SDA pulled low and once with it left high.
      drive_tick(CMD_READ_ACK, 8'h00, 1'b1);
      drive_tick(CMD_NONE, 8'h00, 1'b1);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      drive_tick(CMD_READ_ACK, 8'hFF, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b1);
      drive_tick(CMD_STOP, 8'h00, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      drive_tick(CMD_NONE, 8'h00, 1'b0);
      // Pins must keep their last levels while nothing runs.
      drive_tick(CMD_NONE, 8'hFF, 1'b1);

      // Shrinking the delay in the middle of a long one: the count is already
      // past the new value, so the middle action comes on the next tick.
      write_half_period(8'd255);
      drive_tick(CMD_START, 8'h00, 1'b1);
      repeat (5) drive_tick(CMD_NONE, 8'h00, 1'b1);
      write_half_period(8'd2);
      while (pins.engine_busy()) drive_tick(CMD_NONE, 8'h00, 1'b0);

      // Random part, first with a sluggish receiver.
      hp_list = '{1, 3, 0};
      foreach (hp_list[i]) begin
         write_half_period(HALF_PERIOD_W'(hp_list[i]));
         run_random_ticks(30);
         run_until_idle();
      end

      // Then with a sluggish sender.
      tx_idle_pct = 72;
      rx_idle_pct = 30;
      hp_list = '{2, 6, $urandom_range(5, 1)};
      foreach (hp_list[i]) begin
         write_half_period(HALF_PERIOD_W'(hp_list[i]));
         run_random_ticks(30);
         run_until_idle();
      end

      // Then back to back on both sides.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hp_list = '{1, 4, 1};
      foreach (hp_list[i]) begin
         write_half_period(HALF_PERIOD_W'(hp_list[i]));
         run_random_ticks(30);
         run_until_idle();
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (pins.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver side: take result items with random back-pressure.
   initial begin : result_sink
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) pins.check_pins(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Ends the run if no channel moves an item for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
